// ----- hw/rtl/bse_pkg.sv -----
// Shared types, constants and register codes for the burning ship escape-time block.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package bse_pkg;

    // Default design parameters
    localparam int FRAC_BITS_DEF  = 28;
    localparam int COORD_BITS_DEF = 12;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register field widths
    localparam int WIN_W   = 13;
    localparam int ZOOM_W  = 32;
    localparam int FOCUS_W = 16;
    localparam int ITER_W  = 16;

    // Zoom is Q8.24, so one unit of zoom is 2^24
    localparam int ZOOM_FRAC = 24;

    // Denominator width: 2 * window * 2^24
    localparam int DEN_W = WIN_W + 1 + ZOOM_FRAC;

    // Digit width of the serial multiplier
    localparam int MUL_DIG_W = 32;

    // Register indexes
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    localparam t_cfg_addr CFG_WIDTH    = 3'd0;
    localparam t_cfg_addr CFG_HEIGHT   = 3'd1;
    localparam t_cfg_addr CFG_ZOOM     = 3'd2;
    localparam t_cfg_addr CFG_FOCUS_X  = 3'd3;
    localparam t_cfg_addr CFG_FOCUS_Y  = 3'd4;
    localparam t_cfg_addr CFG_MAX_ITER = 3'd5;

    // Register reset values
    localparam logic [WIN_W-1:0]  WIDTH_RST  = 13'd800;
    localparam logic [WIN_W-1:0]  HEIGHT_RST = 13'd600;
    localparam logic [ZOOM_W-1:0] ZOOM_RST   = 32'h0100_0000;
    localparam logic [ITER_W-1:0] ITER_RST   = 16'd100;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_NUM_PROD,
        S_NUM_SUM,
        S_DIV_LOAD,
        S_DIV_STEP,
        S_DIV_DONE,
        S_MUL_LOAD,
        S_MUL_STEP,
        S_ROUND,
        S_UPDATE,
        S_FINISH
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic in_load;
        logic num_prod;
        logic num_sum;
        logic div_load;
        logic div_step;
        logic c_load;
        logic mul_load;
        logic mul_step;
        logic mul_round;
        logic z_update;
        logic res_esc;
        logic res_limit;
        logic out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic esc;
        logic last;
        logic max_zero;
    } t_stat;

endpackage

// ----- hw/rtl/burning_ship_escape_time_top.sv -----
// Burning ship escape-time evaluator, top level: stream ports and config port.
// Depends on bse_pkg, bse_ctrl and bse_dp (which holds bse_div and bse_mul).
`timescale 1ns / 1ps

// One pixel at a time: a pixel first forms the numerators, then the two serial dividers
// place it in the plane, then the orbit loop runs, each pass of it being operand load,
// NDIG digit steps of the three multipliers, rounding and update, where
// NDIG = ceil((FRAC_BITS + 4) / 32); the pixel then finishes. The loop ends when the
// orbit escapes or when max_iterations passes have run.
// The next pixel is taken as soon as the result sits in the output register.
// Configuration is to be written by the user only while the block is idle; the block itself does not enforce it.

module burning_ship_escape_time_top
    import bse_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    // pixel_x, pixel_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]            s_axis_tdata,
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // out_x, out_y, iter_count
    output logic [((2*COORD_BITS+ITER_W+7)/8)*8-1:0]     m_axis_tdata,
    // escaped
    output logic                                         m_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    input  logic                                         i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]                        i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]                        i_cfg_wdata
);

    localparam int OUT_W = ((2*COORD_BITS + ITER_W + 7) / 8) * 8;

    t_cmd                  w_cmd;
    t_stat                 w_stat;
    logic [COORD_BITS-1:0] w_out_x;
    logic [COORD_BITS-1:0] w_out_y;
    logic [ITER_W-1:0]     w_out_cnt;

    bse_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bse_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_px        (s_axis_tdata[COORD_BITS-1:0]),
        .i_py        (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_x     (w_out_x),
        .o_out_y     (w_out_y),
        .o_out_cnt   (w_out_cnt),
        .o_out_esc   (m_axis_tuser)
    );

    // Pack the result, zero-filled to whole bytes
    assign m_axis_tdata = OUT_W'({w_out_cnt, w_out_y, w_out_x});

endmodule

// ----- hw/rtl/bse_div.sv -----
// Serial restoring divider: floor(num * 2^FRAC_BITS / den), saturated to signed Q4.
// Depends on bse_pkg; one quotient bit per step, FRAC_BITS + 4 steps per division.
`timescale 1ns / 1ps

module bse_div
    import bse_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int NUM_W     = 56
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_step,
    input  logic signed [NUM_W-1:0]       i_num,
    input  logic        [DEN_W-1:0]       i_den,
    output logic signed [FRAC_BITS+3:0]   o_quo
);

    localparam int QW = FRAC_BITS + 4;
    localparam int RW = DEN_W + 4;
    localparam int CW = (NUM_W > RW) ? NUM_W : RW;
    localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};
    localparam logic [QW:0] QLIM_V = (QW+1)'(1) << (QW-1);

    logic [RW-1:0]      r_rem;
    logic [DEN_W+2:0]   r_dsh;
    logic [QW-1:0]      r_quo;
    logic               r_neg;
    logic               r_ovf;

    logic [NUM_W-1:0]   w_mag;
    logic               w_ovf;
    logic               w_ge;
    logic [RW-1:0]      w_diff;
    logic               w_rnz;
    logic [QW:0]        w_v;
    logic [QW:0]        w_neg_v;

    // Magnitude and overflow check: a quotient of 16 or more saturates
    always_comb begin
        w_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        w_ovf = CW'(w_mag) >= CW'({i_den, 4'b0000});
    end

    // Trial subtract of the divisor scaled by 8
    always_comb begin
        w_ge   = r_rem >= RW'(r_dsh);
        w_diff = w_ge ? (r_rem - RW'(r_dsh)) : r_rem;
    end

    // Load operands, then shift in one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= RW'(w_mag);
            r_dsh <= {i_den, 3'b000};
            r_quo <= '0;
            r_neg <= i_num[NUM_W-1];
            r_ovf <= w_ovf;
        end else if (i_step) begin
            r_rem <= {w_diff[RW-2:0], 1'b0};
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    // Round toward minus infinity and saturate
    always_comb begin
        w_rnz   = |r_rem;
        w_v     = {1'b0, r_quo} + (QW+1)'(w_rnz);
        w_neg_v = (QW+1)'(0) - w_v;
        if (!r_neg) begin
            o_quo = (r_ovf || r_quo[QW-1]) ? QMAX : $signed(r_quo);
        end else begin
            o_quo = (r_ovf || (w_v > QLIM_V)) ? QMIN : $signed(w_neg_v[QW-1:0]);
        end
    end

endmodule

// ----- hw/rtl/bse_mul.sv -----
// Digit-serial signed fixed-point multiplier with floor rounding and Q4 saturation.
// Depends on bse_pkg; one MUL_DIG_W-bit digit of the multiplier per step, result on round.
`timescale 1ns / 1ps

module bse_mul
    import bse_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SHIFT     = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_step,
    input  logic                          i_round,
    input  logic signed [FRAC_BITS+3:0]   i_a,
    input  logic signed [FRAC_BITS+3:0]   i_b,
    output logic signed [FRAC_BITS+3:0]   o_res
);

    localparam int QW   = FRAC_BITS + 4;
    localparam int NDIG = (QW + MUL_DIG_W - 1) / MUL_DIG_W;
    localparam int BW   = NDIG * MUL_DIG_W;
    localparam int PW   = QW + BW;
    localparam int QPW  = PW - SHIFT;
    localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};

    logic [QW-1:0]  r_ma;
    logic [BW-1:0]  r_mb;
    logic [PW-1:0]  r_acc;
    logic           r_neg;
    logic signed [QW-1:0] r_res;

    logic [QW-1:0]  w_ma;
    logic [QW-1:0]  w_mb;
    logic [QPW-1:0] w_q;
    logic           w_rem;
    logic           w_big;
    logic [QW-1:0]  w_neg_q;

    // Operand magnitudes
    always_comb begin
        w_ma = i_a[QW-1] ? QW'(-i_a) : QW'(i_a);
        w_mb = i_b[QW-1] ? QW'(-i_b) : QW'(i_b);
    end

    // Load magnitudes, then accumulate one digit per step, most significant first
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ma  <= w_ma;
            r_mb  <= BW'(w_mb);
            r_acc <= '0;
            r_neg <= i_a[QW-1] ^ i_b[QW-1];
        end else if (i_step) begin
            r_acc <= (r_acc << MUL_DIG_W)
                   + PW'(r_ma) * PW'(r_mb[BW-1 -: MUL_DIG_W]);
            r_mb  <= r_mb << MUL_DIG_W;
        end
    end

    // Drop the fraction toward minus infinity and saturate
    always_comb begin
        w_q     = r_acc[PW-1:SHIFT];
        w_rem   = |r_acc[SHIFT-1:0];
        w_big   = |w_q[QPW-1:QW-1];
        w_neg_q = QW'(0) - w_q[QW-1:0] - QW'(w_rem);
    end

    // Hold the rounded product
    always_ff @(posedge i_clk) begin
        if (i_round) begin
            if (!r_neg) begin
                r_res <= w_big ? QMAX : $signed(w_q[QW-1:0]);
            end else begin
                r_res <= w_big ? QMIN : $signed(w_neg_q);
            end
        end
    end

    assign o_res = r_res;

endmodule

// ----- hw/rtl/bse_dp.sv -----
// Datapath: configuration registers, point mapping, dividers, multipliers and orbit update.
// Depends on bse_pkg, bse_div and bse_mul; steered by bse_ctrl through t_cmd and t_stat.
`timescale 1ns / 1ps

module bse_dp
    import bse_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [COORD_BITS-1:0]   i_px,
    input  logic [COORD_BITS-1:0]   i_py,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    output logic [COORD_BITS-1:0]   o_out_x,
    output logic [COORD_BITS-1:0]   o_out_y,
    output logic [ITER_W-1:0]       o_out_cnt,
    output logic                    o_out_esc
);

    localparam int QW     = FRAC_BITS + 4;
    localparam int DIFF_W = ((COORD_BITS > FOCUS_W - 1) ? COORD_BITS : FOCUS_W - 1) + 2;
    localparam int PROD_W = ZOOM_W + 1 + DIFF_W;
    localparam int NUM_W  = PROD_W + 4;
    localparam logic signed [QW+1:0] QMAX_X = (QW+2)'((QW+2)'(1) << (QW-1)) - (QW+2)'(1);
    localparam logic signed [QW+1:0] QMIN_X = -((QW+2)'(1) << (QW-1));
    localparam logic signed [QW:0]   FOUR   = (QW+1)'(1) << (FRAC_BITS + 2);

    // Configuration registers
    logic [WIN_W-1:0]          r_cfg_w;
    logic [WIN_W-1:0]          r_cfg_h;
    logic [ZOOM_W-1:0]         r_cfg_zoom;
    logic signed [FOCUS_W-1:0] r_cfg_fx;
    logic signed [FOCUS_W-1:0] r_cfg_fy;
    logic [ITER_W-1:0]         r_cfg_max;

    // Pixel and mapping registers
    logic [COORD_BITS-1:0]     r_px;
    logic [COORD_BITS-1:0]     r_py;
    logic signed [PROD_W-1:0]  r_prod_re;
    logic signed [PROD_W-1:0]  r_prod_im;
    logic signed [NUM_W-1:0]   r_num_re;
    logic signed [NUM_W-1:0]   r_num_im;

    // Orbit registers
    logic signed [QW-1:0]      r_cre;
    logic signed [QW-1:0]      r_cim;
    logic signed [QW-1:0]      r_zx;
    logic signed [QW-1:0]      r_zy;
    logic [ITER_W-1:0]         r_n;

    // Result and output registers
    logic [ITER_W-1:0]         r_res_cnt;
    logic                      r_res_esc;
    logic [COORD_BITS-1:0]     r_out_x;
    logic [COORD_BITS-1:0]     r_out_y;
    logic [ITER_W-1:0]         r_out_cnt;
    logic                      r_out_esc;

    logic [WIN_W-1:0]          w_w_eff;
    logic [WIN_W-1:0]          w_h_eff;
    logic signed [DIFF_W-1:0]  w_dx;
    logic signed [DIFF_W-1:0]  w_dy;
    logic signed [NUM_W-1:0]   w_p7;
    logic signed [NUM_W-1:0]   w_fx7;
    logic signed [NUM_W-1:0]   w_w5;
    logic signed [NUM_W-1:0]   w_p2;
    logic signed [NUM_W-1:0]   w_fy2;
    logic signed [NUM_W-1:0]   w_hs;
    logic [DEN_W-1:0]          w_den_re;
    logic [DEN_W-1:0]          w_den_im;
    logic signed [QW-1:0]      w_cre;
    logic signed [QW-1:0]      w_cim;
    logic signed [QW-1:0]      w_xx;
    logic signed [QW-1:0]      w_yy;
    logic signed [QW-1:0]      w_xy;
    logic signed [QW:0]        w_r2;
    logic signed [QW-1:0]      w_nx;
    logic signed [QW+1:0]      w_nx_abs;
    logic signed [QW-1:0]      w_zx_new;
    logic signed [QW+1:0]      w_xy_abs;
    logic signed [QW-1:0]      w_zy_new;

    function automatic logic signed [QW-1:0] f_sat(input logic signed [QW+1:0] v);
        logic signed [QW-1:0] r;
        if (v > QMAX_X) begin
            r = QMAX_X[QW-1:0];
        end else if (v < QMIN_X) begin
            r = QMIN_X[QW-1:0];
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    // Write configuration registers; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= WIDTH_RST;
            r_cfg_h    <= HEIGHT_RST;
            r_cfg_zoom <= ZOOM_RST;
            r_cfg_fx   <= '0;
            r_cfg_fy   <= '0;
            r_cfg_max  <= ITER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WIDTH:    r_cfg_w    <= i_cfg_wdata[WIN_W-1:0];
                CFG_HEIGHT:   r_cfg_h    <= i_cfg_wdata[WIN_W-1:0];
                CFG_ZOOM:     r_cfg_zoom <= i_cfg_wdata[ZOOM_W-1:0];
                CFG_FOCUS_X:  r_cfg_fx   <= $signed(i_cfg_wdata[FOCUS_W-1:0]);
                CFG_FOCUS_Y:  r_cfg_fy   <= $signed(i_cfg_wdata[FOCUS_W-1:0]);
                CFG_MAX_ITER: r_cfg_max  <= i_cfg_wdata[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero window size acts as one pixel
    always_comb begin
        w_w_eff  = (r_cfg_w == '0) ? WIN_W'(1) : r_cfg_w;
        w_h_eff  = (r_cfg_h == '0) ? WIN_W'(1) : r_cfg_h;
        w_den_re = DEN_W'({w_w_eff, 1'b0}) << ZOOM_FRAC;
        w_den_im = DEN_W'(w_h_eff) << ZOOM_FRAC;
    end

    // Offsets from the zoom center
    always_comb begin
        w_dx = $signed(DIFF_W'(r_px)) - DIFF_W'(r_cfg_fx);
        w_dy = $signed(DIFF_W'(r_py)) - DIFF_W'(r_cfg_fy);
    end

    // Numerator terms: re = 7Z(x-fx) + 7fx - 5W, im = 2Z(y-fy) + 2fy - H, in units of 2^-24
    always_comb begin
        w_p7  = (NUM_W'(r_prod_re) <<< 3) - NUM_W'(r_prod_re);
        w_fx7 = ((NUM_W'(r_cfg_fx) <<< 3) - NUM_W'(r_cfg_fx)) <<< ZOOM_FRAC;
        w_w5  = $signed((NUM_W'(w_w_eff) << 2) + NUM_W'(w_w_eff)) <<< ZOOM_FRAC;
        w_p2  = NUM_W'(r_prod_im) <<< 1;
        w_fy2 = NUM_W'(r_cfg_fy) <<< (ZOOM_FRAC + 1);
        w_hs  = $signed(NUM_W'(w_h_eff)) <<< ZOOM_FRAC;
    end

    // Capture the pixel and build the numerators
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_px <= i_px;
            r_py <= i_py;
        end
        if (i_cmd.num_prod) begin
            r_prod_re <= $signed({1'b0, r_cfg_zoom}) * w_dx;
            r_prod_im <= $signed({1'b0, r_cfg_zoom}) * w_dy;
        end
        if (i_cmd.num_sum) begin
            r_num_re <= w_p7 + w_fx7 - w_w5;
            r_num_im <= w_p2 + w_fy2 - w_hs;
        end
    end

    bse_div #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W)
    ) u_div_re (
        .i_clk  (i_clk),
        .i_load (i_cmd.div_load),
        .i_step (i_cmd.div_step),
        .i_num  (r_num_re),
        .i_den  (w_den_re),
        .o_quo  (w_cre)
    );

    bse_div #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W)
    ) u_div_im (
        .i_clk  (i_clk),
        .i_load (i_cmd.div_load),
        .i_step (i_cmd.div_step),
        .i_num  (r_num_im),
        .i_den  (w_den_im),
        .o_quo  (w_cim)
    );

    bse_mul #(
        .FRAC_BITS (FRAC_BITS),
        .SHIFT     (FRAC_BITS)
    ) u_mul_xx (
        .i_clk   (i_clk),
        .i_load  (i_cmd.mul_load),
        .i_step  (i_cmd.mul_step),
        .i_round (i_cmd.mul_round),
        .i_a     (r_zx),
        .i_b     (r_zx),
        .o_res   (w_xx)
    );

    bse_mul #(
        .FRAC_BITS (FRAC_BITS),
        .SHIFT     (FRAC_BITS)
    ) u_mul_yy (
        .i_clk   (i_clk),
        .i_load  (i_cmd.mul_load),
        .i_step  (i_cmd.mul_step),
        .i_round (i_cmd.mul_round),
        .i_a     (r_zy),
        .i_b     (r_zy),
        .o_res   (w_yy)
    );

    // Shift one less for the doubled cross term
    bse_mul #(
        .FRAC_BITS (FRAC_BITS),
        .SHIFT     (FRAC_BITS - 1)
    ) u_mul_xy (
        .i_clk   (i_clk),
        .i_load  (i_cmd.mul_load),
        .i_step  (i_cmd.mul_step),
        .i_round (i_cmd.mul_round),
        .i_a     (r_zx),
        .i_b     (r_zy),
        .o_res   (w_xy)
    );

    // Escape test and next orbit point
    always_comb begin
        w_r2     = (QW+1)'(w_xx) + (QW+1)'(w_yy);
        w_nx     = f_sat((QW+2)'(w_xx) - (QW+2)'(w_yy) + (QW+2)'(r_cre));
        w_nx_abs = w_nx[QW-1] ? -(QW+2)'(w_nx) : (QW+2)'(w_nx);
        w_zx_new = f_sat(w_nx_abs);
        w_xy_abs = w_xy[QW-1] ? -(QW+2)'(w_xy) : (QW+2)'(w_xy);
        w_zy_new = f_sat(w_xy_abs + (QW+2)'(r_cim));
    end

    // Advance the orbit
    always_ff @(posedge i_clk) begin
        if (i_cmd.c_load) begin
            r_cre <= w_cre;
            r_cim <= w_cim;
            r_zx  <= w_cre;
            r_zy  <= w_cim;
            r_n   <= '0;
        end else if (i_cmd.z_update) begin
            r_zx  <= w_zx_new;
            r_zy  <= w_zy_new;
            r_n   <= r_n + ITER_W'(1);
        end
    end

    // Record the outcome, then hand it to the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_esc) begin
            r_res_cnt <= r_n;
            r_res_esc <= 1'b1;
        end else if (i_cmd.res_limit) begin
            r_res_cnt <= '0;
            r_res_esc <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_x   <= r_px;
            r_out_y   <= r_py;
            r_out_cnt <= r_res_cnt;
            r_out_esc <= r_res_esc;
        end
    end

    always_comb begin
        o_stat.esc      = w_r2 > FOUR;
        o_stat.last     = ({1'b0, r_n} + (ITER_W+1)'(1)) == {1'b0, r_cfg_max};
        o_stat.max_zero = r_cfg_max == '0;
    end

    assign o_out_x   = r_out_x;
    assign o_out_y   = r_out_y;
    assign o_out_cnt = r_out_cnt;
    assign o_out_esc = r_out_esc;

endmodule

// ----- hw/rtl/bse_ctrl.sv -----
// Controller state machine: sequences mapping, division, the iteration loop and output.
// Depends on bse_pkg; drives bse_dp through t_cmd and reads t_stat.
`timescale 1ns / 1ps

module bse_ctrl
    import bse_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_stat   i_stat,
    output t_cmd    o_cmd
);

    localparam int QW    = FRAC_BITS + 4;
    localparam int NDIG  = (QW + MUL_DIG_W - 1) / MUL_DIG_W;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QW - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(NDIG - 1);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;

    // State, step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_NUM_PROD;
            end
            S_NUM_PROD: n_state = S_NUM_SUM;
            S_NUM_SUM:  n_state = S_DIV_LOAD;
            S_DIV_LOAD: begin
                n_cnt   = '0;
                n_state = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DIV_DONE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DIV_DONE: begin
                n_state = i_stat.max_zero ? S_FINISH : S_MUL_LOAD;
            end
            S_MUL_LOAD: begin
                n_cnt   = '0;
                n_state = S_MUL_STEP;
            end
            S_MUL_STEP: begin
                if (r_cnt == MUL_LAST) begin
                    n_state = S_ROUND;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_ROUND: n_state = S_UPDATE;
            S_UPDATE: begin
                n_state = (i_stat.esc || i_stat.last) ? S_FINISH : S_MUL_LOAD;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands; hold the input closed while reset is asserted
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = i_rst_n;
                o_cmd.in_load = i_in_valid && i_rst_n;
            end
            S_NUM_PROD: o_cmd.num_prod = 1'b1;
            S_NUM_SUM:  o_cmd.num_sum  = 1'b1;
            S_DIV_LOAD: o_cmd.div_load = 1'b1;
            S_DIV_STEP: o_cmd.div_step = 1'b1;
            S_DIV_DONE: begin
                o_cmd.c_load    = 1'b1;
                o_cmd.res_limit = i_stat.max_zero;
            end
            S_MUL_LOAD: o_cmd.mul_load  = 1'b1;
            S_MUL_STEP: o_cmd.mul_step  = 1'b1;
            S_ROUND:    o_cmd.mul_round = 1'b1;
            S_UPDATE: begin
                o_cmd.res_esc   = i_stat.esc;
                o_cmd.res_limit = !i_stat.esc && i_stat.last;
                o_cmd.z_update  = !i_stat.esc && !i_stat.last;
            end
            S_FINISH: o_cmd.out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;

    // Divider step count stays within the quotient width
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_STEP) |-> (r_cnt <= DIV_LAST))
        else $error("divider step count out of range");

    // An accepted pixel closes the input until its result is done
    a_one_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a pixel is in flight");

    // The output register is loaded only when free or being drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");

    // An escape ends the loop at once
    a_esc_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && i_stat.esc) |=> (r_state == S_FINISH))
        else $error("escape did not end the iteration loop");

endmodule

// ----- tb/burning_ship_escape_time_top_tb.sv -----
// Testbench for burning_ship_escape_time_top: streams pixels in, checks every result.
// A scoreboard class predicts count and escape flag per pixel; depends on bse_pkg.
`timescale 1ns / 1ps

localparam int TB_FRAC     = bse_pkg::FRAC_BITS_DEF;
localparam int TB_COORD    = bse_pkg::COORD_BITS_DEF;
localparam int TB_M_DATA_W = ((2 * TB_COORD + bse_pkg::ITER_W + 7) / 8) * 8;
localparam longint Q_MAX   = (64'sd1 <<< (TB_FRAC + 3)) - 1;
localparam longint Q_MIN   = -Q_MAX - 1;

typedef struct {
    logic [TB_COORD-1:0]        px;
    logic [TB_COORD-1:0]        py;
    logic [bse_pkg::ITER_W-1:0] iters;
    logic                       esc;
} escape_result_t;

// Register copy, escape-time predictor and queue of pending results
class escape_scoreboard;
    logic [bse_pkg::WIN_W-1:0]          win_w;
    logic [bse_pkg::WIN_W-1:0]          win_h;
    logic [bse_pkg::ZOOM_W-1:0]         zoom;
    logic signed [bse_pkg::FOCUS_W-1:0] focus_x;
    logic signed [bse_pkg::FOCUS_W-1:0] focus_y;
    logic [bse_pkg::ITER_W-1:0]         iter_limit;
    escape_result_t                     expected_escapes[$];
    int mismatches   = 0;
    int checked      = 0;
    int escaped_seen = 0;
    int limit_seen   = 0;

    function void reset_regs();
        win_w      = bse_pkg::WIDTH_RST;
        win_h      = bse_pkg::HEIGHT_RST;
        zoom       = bse_pkg::ZOOM_RST;
        focus_x    = '0;
        focus_y    = '0;
        iter_limit = bse_pkg::ITER_RST;
    endfunction

    function void write_reg(bse_pkg::t_cfg_addr addr, logic [31:0] value);
        case (addr)
            bse_pkg::CFG_WIDTH:    win_w      = value[bse_pkg::WIN_W-1:0];
            bse_pkg::CFG_HEIGHT:   win_h      = value[bse_pkg::WIN_W-1:0];
            bse_pkg::CFG_ZOOM:     zoom       = value[bse_pkg::ZOOM_W-1:0];
            bse_pkg::CFG_FOCUS_X:  focus_x    = value[bse_pkg::FOCUS_W-1:0];
            bse_pkg::CFG_FOCUS_Y:  focus_y    = value[bse_pkg::FOCUS_W-1:0];
            bse_pkg::CFG_MAX_ITER: iter_limit = value[bse_pkg::ITER_W-1:0];
            default: ;
        endcase
    endfunction

    function longint clamp_q(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // Product of two Q4 values, floored at the given shift and saturated
    function longint mul_floor(longint a, longint b, int sh);
        longint p;
        p = a * b;
        return clamp_q(p >>> sh);
    endfunction

    // floor(num * 2^FRAC / den), saturated; den is positive
    function longint ratio_floor(longint num, longint den);
        logic signed [127:0] n;
        logic signed [127:0] d;
        logic signed [127:0] q;
        n = num;
        d = den;
        n = n <<< TB_FRAC;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        if (q > Q_MAX) return Q_MAX;
        if (q < Q_MIN) return Q_MIN;
        return longint'(q);
    endfunction

    // Map the pixel into the plane, run the orbit and queue the result
    function void take_pixel(logic [TB_COORD-1:0] px, logic [TB_COORD-1:0] py);
        longint w, h, z, fx, fy, xp, yp, one, four;
        longint cre, cim, zx, zy, xx, yy, nx, ny;
        int unsigned n;
        escape_result_t r;
        w    = (win_w == 0) ? 1 : {51'd0, win_w};
        h    = (win_h == 0) ? 1 : {51'd0, win_h};
        z    = {32'd0, zoom};
        fx   = focus_x;
        fy   = focus_y;
        xp   = {52'd0, px};
        yp   = {52'd0, py};
        one  = 64'sd1 <<< bse_pkg::ZOOM_FRAC;
        four = 64'sd4 <<< TB_FRAC;
        cre  = ratio_floor(7 * z * (xp - fx) + 7 * fx * one - 5 * w * one, 2 * w * one);
        cim  = ratio_floor(2 * z * (yp - fy) + 2 * fy * one - h * one, h * one);
        zx   = cre;
        zy   = cim;
        n    = 0;
        while (n < iter_limit) begin
            xx = mul_floor(zx, zx, TB_FRAC);
            yy = mul_floor(zy, zy, TB_FRAC);
            if (xx + yy > four) break;
            nx = clamp_q(xx - yy + cre);
            ny = mul_floor(zx, zy, TB_FRAC - 1);
            ny = clamp_q(((ny < 0) ? -ny : ny) + cim);
            zx = clamp_q((nx < 0) ? -nx : nx);
            zy = ny;
            n++;
        end
        r.px    = px;
        r.py    = py;
        r.esc   = (n < iter_limit);
        r.iters = r.esc ? n[bse_pkg::ITER_W-1:0] : '0;
        expected_escapes.push_back(r);
    endfunction

    function void match_field(string field, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // Compare one output transaction with the oldest pending prediction
    function void check_output(logic [TB_M_DATA_W-1:0] data, logic esc);
        escape_result_t r;
        if (expected_escapes.size() == 0) begin
            $error("unexpected result for pixel (%0d,%0d)",
                   data[TB_COORD-1:0], data[2*TB_COORD-1:TB_COORD]);
            mismatches++;
            return;
        end
        r = expected_escapes.pop_front();
        checked++;
        if (r.esc) escaped_seen++;
        else limit_seen++;
        match_field("out_x", r.px, data[TB_COORD-1:0]);
        match_field("out_y", r.py, data[2*TB_COORD-1:TB_COORD]);
        match_field("iter_count", r.iters,
                    data[2*TB_COORD+bse_pkg::ITER_W-1:2*TB_COORD]);
        match_field("escaped", r.esc, esc);
    endfunction

    function int pending();
        return expected_escapes.size();
    endfunction
endclass

module burning_ship_escape_time_top_tb;
    import bse_pkg::*;

    localparam int     CLK_PERIOD      = 12;
    localparam int     S_DATA_W        = ((2 * TB_COORD + 7) / 8) * 8;
    localparam int     RANDOM_VIEWS    = 10;
    localparam int     PIXELS_PER_VIEW = 65;
    localparam int     HOLD_OFF_CYCLES = 3000;
    localparam int     CFG_SETTLE      = 8;
    localparam int     END_SETTLE      = 64;
    localparam longint TIMEOUT_CYCLES  = 3_000_000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic [S_DATA_W-1:0]    s_axis_tdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TB_M_DATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic                   i_cfg_we;
    t_cfg_addr              i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;

    escape_scoreboard sb;
    bit tx_gaps     = 1'b1;
    bit rx_steady   = 1'b0;
    int rx_hold_len = 0;
    int views_run   = 0;

    burning_ship_escape_time_top #(
        .FRAC_BITS  (TB_FRAC),
        .COORD_BITS (TB_COORD)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Watch both streams: check results first, then record accepted pixels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_output(m_axis_tdata, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                sb.take_pixel(s_axis_tdata[TB_COORD-1:0],
                              s_axis_tdata[2*TB_COORD-1:TB_COORD]);
        end
    end

    // Result side: random ready pattern, steady stretches and one long hold-off
    initial begin : result_sink
        int stretch;
        bit rdy;
        forever begin
            if (rx_hold_len > 0) begin
                rdy         = 1'b0;
                stretch     = rx_hold_len;
                rx_hold_len = 0;
            end else if (rx_steady || $urandom_range(0, 2) != 0) begin
                rdy     = 1'b1;
                stretch = rx_steady ? 1 : $urandom_range(1, 12);
            end else begin
                rdy     = 1'b0;
                stretch = 1 + idle_len();
            end
            m_axis_tready <= rdy;
            repeat (stretch) @(posedge i_clk);
        end
    end

    // Offer one pixel and hold it until the transaction completes
    task automatic send_pixel(input logic [TB_COORD-1:0] px, input logic [TB_COORD-1:0] py);
        int gap;
        gap = tx_gaps ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_DATA_W'({py, px});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (CFG_SETTLE) @(posedge i_clk);
    endtask

    // Write all six registers on consecutive cycles; block must be idle
    task automatic program_view(input logic [WIN_W-1:0] w, input logic [WIN_W-1:0] h,
                                input logic [ZOOM_W-1:0] zm, input logic [FOCUS_W-1:0] fx,
                                input logic [FOCUS_W-1:0] fy, input logic [ITER_W-1:0] mx);
        t_cfg_addr   addrs[6];
        logic [31:0] vals[6];
        addrs = '{CFG_WIDTH, CFG_HEIGHT, CFG_ZOOM, CFG_FOCUS_X, CFG_FOCUS_Y, CFG_MAX_ITER};
        vals  = '{32'(w), 32'(h), 32'(zm), 32'(fx), 32'(fy), 32'(mx)};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= addrs[i];
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            sb.write_reg(addrs[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
        views_run++;
    endtask

    function automatic logic [WIN_W-1:0] pick_window();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 8191);
        if (r == 1) return $urandom_range(1, 16);
        return $urandom_range(64, 4096);
    endfunction

    // Mostly inside the window, sometimes anywhere in the coordinate range
    function automatic logic [TB_COORD-1:0] pick_coord(input int span);
        if (span > 4096) span = 4096;
        if (span < 1) span = 1;
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, span - 1);
        return $urandom_range(0, 4095);
    endfunction

    // Random register set, then a burst of pixels mostly inside the view
    task automatic random_view();
        logic [WIN_W-1:0]   w, h;
        logic [ZOOM_W-1:0]  zm;
        logic [FOCUS_W-1:0] fx, fy;
        logic [ITER_W-1:0]  mx;
        int r;
        w = pick_window();
        h = pick_window();
        r = $urandom_range(0, 9);
        if (r < 6) zm = $urandom_range(32'h0040_0000, 32'h1000_0000);
        else if (r < 8) zm = $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
        else zm = $urandom();
        if ($urandom_range(0, 9) < 7) fx = $urandom_range(0, (w == 0) ? 0 : w - 1);
        else fx = $urandom();
        if ($urandom_range(0, 9) < 7) fy = $urandom_range(0, (h == 0) ? 0 : h - 1);
        else fy = $urandom();
        r = $urandom_range(0, 9);
        if (r == 0) mx = $urandom_range(0, 4);
        else if (r < 8) mx = $urandom_range(5, 64);
        else mx = $urandom_range(65, 128);
        program_view(w, h, zm, fx, fy, mx);
        for (int k = 0; k < PIXELS_PER_VIEW; k++)
            send_pixel(pick_coord(w), pick_coord(h));
        drain();
    endtask

    // Main sequence: reset, directed views, random views, final report
    initial begin : stimulus
        sb = new;
        sb.reset_regs();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CFG_WIDTH;
        i_cfg_wdata   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values: corners, far points, points held in the set
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd571, 12'd300);
        send_pixel(12'd400, 12'd300);
        send_pixel(12'd100, 12'd200);
        drain();

        // Zero window acts as one, zero zoom, focus at its extremes, limit of one
        program_view(13'd0, 13'd0, 32'd0, 16'h8000, 16'h7FFF, 16'd1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd1);
        drain();

        // Zero limit: no step runs at all
        program_view(13'd4096, 13'd4096, ZOOM_RST, 16'd2048, 16'd2048, 16'd0);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        drain();

        // Largest zoom and limit; every point here escapes at once
        program_view(13'd1, 13'd1, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'hFFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd0, 12'd1);
        send_pixel(12'd4095, 12'd4095);
        drain();

        // Largest window field with focus at the opposite extremes
        program_view(13'd8191, 13'd8191, ZOOM_RST, 16'h7FFF, 16'h8000, 16'd2);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1234, 12'd3000);
        drain();

        // Random views: first with a long hold-off, then one with no idling
        for (int v = 0; v < RANDOM_VIEWS; v++) begin
            tx_gaps     = (v > 1);
            rx_steady   = (v == 1);
            if (v == 0) rx_hold_len = HOLD_OFF_CYCLES;
            random_view();
        end
        rx_steady = 1'b0;

        repeat (END_SETTLE) @(posedge i_clk);
        $display("Checked %0d pixel results over %0d register settings after reset.",
                 sb.checked, views_run);
        $display("%0d orbits escaped, %0d hit the iteration limit.",
                 sb.escaped_seen, sb.limit_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("TB_ERROR");
        $finish;
    end

endmodule
